// ===== rtl/ebiq_pkg.sv =====
`timescale 1ns / 1ps

package ebiq_pkg;

	localparam int TIME_W      = 32;
	localparam int THR_W       = 16;
	localparam int ACT_W       = 3;
	localparam int BTN_PINS    = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 8;

	localparam int NUM_BUTTONS_DEF = 3;

	localparam logic [THR_W-1:0] LONG_PRESS_RST  = THR_W'(1000);
	localparam logic [THR_W-1:0] SHORT_PRESS_RST = THR_W'(20);
	localparam logic [THR_W-1:0] DEBOUNCE_RST    = THR_W'(20);

	localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CW    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CCW   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PRESS = 3'd3;
	localparam logic [ACT_W-1:0] ACT_LONG  = 3'd4;
	localparam int               ACT_BTN_BASE = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_PRESS = 2'd0,
		CFG_SHORT_PRESS = 2'd1,
		CFG_DEBOUNCE = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_POLL = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [BTN_PINS-1:0] buttons_down;
		logic                enc_switch_down;
		logic                enc_b_level;
		logic                enc_a_level;
		logic [TIME_W-1:0]   now_ms;
	} poll_t;

endpackage

// ===== rtl/ebiq_btn_debounce.sv =====
`timescale 1ns / 1ps

module ebiq_btn_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [ebiq_pkg::TIME_W-1:0]   now_ms,
	input  logic                          pressed,
	input  logic [ebiq_pkg::THR_W-1:0]    debounce_ms,
	output logic                          fire
);
	import ebiq_pkg::*;

	logic [TIME_W-1:0] change_time_q;
	logic              prev_q;
	logic [TIME_W-1:0] held;

	assign held = now_ms - change_time_q;
	// a change restarts the timer, so only a stable press can post
	assign fire = pressed && (pressed == prev_q) && (held > {16'd0, debounce_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_time_q <= '0;
			prev_q        <= 1'b0;
		end else if (step) begin
			if (pressed != prev_q) begin
				change_time_q <= now_ms;
			end
			prev_q <= pressed;
		end
	end

endmodule

// ===== rtl/encoder_button_input_qualifier.sv =====
`timescale 1ns / 1ps
// path: each word is registered in the input stage and then in the result register,
// and a low m_tready can hold it in the input stage between the two
// throughput: one word per cycle unless m_tready stalls, set by the input stage and
// the result register; state is updated in the single compute stage between them
// reset: arst_n clears pending action, encoder priming, switch and button timers,
// and restores the thresholds to 1000, 20 and 20 ms

module encoder_button_input_qualifier #(
	parameter int NUM_BUTTONS = ebiq_pkg::NUM_BUTTONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_ms[31:0], enc_a_level, enc_b_level, enc_switch_down, buttons_down[2:0], zero pad
	input  logic [ebiq_pkg::IN_DATA_W-1:0]    s_tdata,
	// opcode
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// action[2:0], zero pad
	output logic [ebiq_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [ebiq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ebiq_pkg::THR_W-1:0]        cfg_data
);
	import ebiq_pkg::*;

	logic [THR_W-1:0]  long_press_q;
	logic [THR_W-1:0]  short_press_q;
	logic [THR_W-1:0]  debounce_q;

	logic              valid_s1;
	opcode_t           op_s1;
	poll_t             poll_s1;

	logic              m_valid_q;
	logic [ACT_W-1:0]  action_q;

	logic [ACT_W-1:0]  pending_q;
	logic              prev_a_q;
	logic              primed_q;
	logic [TIME_W-1:0] switch_down_time_q;
	logic              switch_was_down_q;

	logic              adv;
	logic              step;
	logic              poll_step;
	logic [TIME_W-1:0] switch_held;
	logic [NUM_BUTTONS-1:0] fire;
	logic [ACT_W-1:0]  poll_action;

	assign adv       = !m_valid_q || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign step      = valid_s1 && adv;
	assign poll_step = step && (op_s1 == OP_POLL);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= LONG_PRESS_RST;
			short_press_q <= SHORT_PRESS_RST;
			debounce_q    <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LONG_PRESS:  long_press_q  <= cfg_data;
				CFG_SHORT_PRESS: short_press_q <= cfg_data;
				CFG_DEBOUNCE:    debounce_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= opcode_t'(s_tuser);
			poll_s1 <= poll_t'(s_tdata[$bits(poll_t)-1:0]);
		end
	end

	// buttons
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		logic pressed;
		if (i < BTN_PINS) begin : g_pin
			assign pressed = poll_s1.buttons_down[i];
		end else begin : g_nopin
			assign pressed = 1'b0;
		end
		ebiq_btn_debounce u_deb (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (poll_step),
			.now_ms      (poll_s1.now_ms),
			.pressed     (pressed),
			.debounce_ms (debounce_q),
			.fire        (fire[i])
		);
	end

	assign switch_held = poll_s1.now_ms - switch_down_time_q;

	// later rules win: encoder, switch, then buttons in order
	always_comb begin
		poll_action = pending_q;
		if (primed_q && prev_a_q && !poll_s1.enc_a_level) begin
			poll_action = poll_s1.enc_b_level ? ACT_CCW : ACT_CW;
		end
		if (!poll_s1.enc_switch_down && switch_was_down_q) begin
			if (switch_held > {16'd0, long_press_q}) begin
				poll_action = ACT_LONG;
			end else if (switch_held > {16'd0, short_press_q}) begin
				poll_action = ACT_PRESS;
			end
		end
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (fire[i]) begin
				poll_action = ACT_W'(ACT_BTN_BASE + i);
			end
		end
	end

	// qualifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q          <= ACT_NONE;
			prev_a_q           <= 1'b1;
			primed_q           <= 1'b0;
			switch_down_time_q <= '0;
			switch_was_down_q  <= 1'b0;
		end else if (step) begin
			if (op_s1 == OP_READ) begin
				pending_q <= ACT_NONE;
			end else begin
				pending_q <= poll_action;
				prev_a_q  <= poll_s1.enc_a_level;
				primed_q  <= 1'b1;
				if (poll_s1.enc_switch_down && !switch_was_down_q) begin
					switch_down_time_q <= poll_s1.now_ms;
					switch_was_down_q  <= 1'b1;
				end else if (!poll_s1.enc_switch_down && switch_was_down_q) begin
					switch_was_down_q  <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			action_q <= (op_s1 == OP_READ) ? pending_q : poll_action;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-ACT_W){1'b0}}, action_q};

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && op_s1 == OP_READ) |=> (pending_q == ACT_NONE))
		else $error("pending action not cleared after read");

	a_read_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(step && op_s1 == OP_READ) |=> (action_q == $past(pending_q)))
		else $error("read did not return pending action");

	a_poll_primes: assert property (@(posedge clk) disable iff (!arst_n)
		poll_step |=> primed_q)
		else $error("encoder not primed after poll");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(poll_s1) && $stable(op_s1)))
		else $error("input stage lost a word while stalled");

	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		poll_step |=> (action_q == pending_q))
		else $error("poll result differs from pending action");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ebiq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	// predicted block state
	logic [ACT_W-1:0] pend_act = ACT_NONE;
	bit prev_a = 1'b1;
	bit primed = 1'b0;
	bit sw_held = 1'b0;
	logic [TIME_W-1:0] sw_press_ms = '0;
	logic [TIME_W-1:0] btn_change_ms [BTN_PINS] = '{default: '0};
	bit btn_prev [BTN_PINS] = '{default: 1'b0};
	logic [THR_W-1:0] long_thr = LONG_PRESS_RST;
	logic [THR_W-1:0] short_thr = SHORT_PRESS_RST;
	logic [THR_W-1:0] deb_thr = DEBOUNCE_RST;

	logic [ACT_W-1:0] due_actions [$];
	logic [TIME_W-1:0] clock_ms = '0;
	bit pin_a = 1'b1;
	bit pin_sw = 1'b0;
	logic [BTN_PINS-1:0] pin_btns = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int words_sent = 0;
	int words_checked = 0;
	int settings_used = 1;

	encoder_button_input_qualifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [ACT_W-1:0] predict_action(input opcode_t op, input poll_t p);
		logic [ACT_W-1:0] act;
		logic [TIME_W-1:0] held;
		bit cur;
		if (op == OP_READ) begin
			act = pend_act;
			pend_act = ACT_NONE;
			return act;
		end
		if (!primed) begin
			primed = 1'b1;
		end else if (p.enc_a_level != prev_a && !p.enc_a_level) begin
			pend_act = p.enc_b_level ? ACT_CCW : ACT_CW;
		end
		prev_a = p.enc_a_level;
		if (p.enc_switch_down && !sw_held) begin
			sw_press_ms = p.now_ms;
			sw_held = 1'b1;
		end else if (!p.enc_switch_down && sw_held) begin
			held = p.now_ms - sw_press_ms;
			if (held > long_thr)
				pend_act = ACT_LONG;
			else if (held > short_thr)
				pend_act = ACT_PRESS;
			sw_held = 1'b0;
		end
		for (int i = 0; i < BTN_PINS; i++) begin
			cur = p.buttons_down[i];
			if (cur != btn_prev[i])
				btn_change_ms[i] = p.now_ms;
			if (cur && TIME_W'(p.now_ms - btn_change_ms[i]) > deb_thr)
				pend_act = ACT_W'(ACT_BTN_BASE + i);
			btn_prev[i] = cur;
		end
		return pend_act;
	endfunction

	// result side: check each word, then choose tready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_actions.size() == 0) begin
				$display("%0t: unexpected result word, actual %0h", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== OUT_DATA_W'(due_actions[0])) begin
					$display("%0t: action mismatch, expected %0d actual %0h",
						$time, due_actions[0], m_tdata);
					errors++;
				end
				void'(due_actions.pop_front());
				words_checked++;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input opcode_t op, input poll_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'(p);
		do @(posedge clk); while (!s_tready);
		due_actions.push_back(predict_action(op, p));
		words_sent++;
	endtask

	task automatic poll(input int unsigned step_ms, input bit a, input bit b, input bit sw,
			input logic [BTN_PINS-1:0] btns);
		poll_t p;
		clock_ms += step_ms;
		pin_a = a;
		pin_sw = sw;
		pin_btns = btns;
		p.now_ms = clock_ms;
		p.enc_a_level = a;
		p.enc_b_level = b;
		p.enc_switch_down = sw;
		p.buttons_down = btns;
		send_word(OP_POLL, p);
	endtask

	// pin and time fields of a read carry noise
	task automatic read_action();
		logic [63:0] r;
		poll_t junk;
		r = {$urandom, $urandom};
		junk = r[$bits(poll_t)-1:0];
		send_word(OP_READ, junk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_actions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_threshold(input cfg_idx_t idx, input logic [THR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LONG_PRESS: long_thr = val;
			CFG_SHORT_PRESS: short_thr = val;
			CFG_DEBOUNCE: deb_thr = val;
			default: ;
		endcase
	endtask

	task automatic set_all_thresholds(input logic [THR_W-1:0] lp, input logic [THR_W-1:0] sp,
			input logic [THR_W-1:0] db);
		settle();
		set_threshold(CFG_LONG_PRESS, lp);
		set_threshold(CFG_SHORT_PRESS, sp);
		set_threshold(CFG_DEBOUNCE, db);
		settings_used++;
	endtask

	task automatic random_words(input int count);
		int unsigned sel;
		int unsigned step_ms;
		int unsigned mid;
		bit a;
		bit b;
		bit sw;
		logic [BTN_PINS-1:0] btns;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 25) begin
				read_action();
			end else begin
				a = ($urandom_range(99) < 30) ? !pin_a : pin_a;
				b = 1'($urandom_range(1));
				sw = ($urandom_range(99) < 15) ? !pin_sw : pin_sw;
				btns = pin_btns;
				for (int i = 0; i < BTN_PINS; i++)
					if ($urandom_range(99) < 20)
						btns[i] = !btns[i];
				mid = 2 * ((short_thr > deb_thr) ? short_thr : deb_thr) + 2;
				sel = $urandom_range(99);
				if (sel < 50)
					step_ms = $urandom_range(8);
				else if (sel < 80)
					step_ms = $urandom_range(mid);
				else if (sel < 95)
					step_ms = $urandom_range(long_thr / 4 + 2);
				else
					step_ms = $urandom_range(2 * long_thr + 2);
				if ($urandom_range(99) < 2)
					clock_ms = $urandom;
				poll(step_ms, a, b, sw, btns);
			end
		end
	endtask

	task automatic test_first_poll_and_encoder();
		read_action();
		clock_ms = 32'hFFFF_FFF0;
		// a low on the very first poll must not decode
		poll(0, 1'b0, 1'b1, 1'b0, 3'b000);
		poll(1, 1'b1, 1'b0, 1'b0, 3'b000);
		poll(1, 1'b0, 1'b0, 1'b0, 3'b000);
		poll(1, 1'b1, 1'b1, 1'b0, 3'b000);
		poll(1, 1'b0, 1'b1, 1'b0, 3'b000);
	endtask

	task automatic test_switch_timing();
		clock_ms = 32'hFFFF_FFF8;
		// hold spans the timestamp wrap
		poll(0, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(24, 1'b0, 1'b0, 1'b0, 3'b000);
		poll(5, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(1500, 1'b0, 1'b0, 1'b0, 3'b000);
		poll(3, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(20, 1'b0, 1'b0, 1'b0, 3'b000);
	endtask

	task automatic test_button_debounce();
		poll(1, 1'b0, 1'b0, 1'b0, 3'b111);
		poll(21, 1'b0, 1'b0, 1'b0, 3'b111);
		poll(5, 1'b0, 1'b0, 1'b0, 3'b001);
		read_action();
	endtask

	task automatic test_event_priority();
		poll(1, 1'b1, 1'b0, 1'b1, 3'b010);
		poll(50, 1'b0, 1'b1, 1'b0, 3'b010);
	endtask

	task automatic test_threshold_extremes();
		set_all_thresholds('0, '0, '0);
		poll(1, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(1, 1'b0, 1'b0, 1'b0, 3'b000);
		poll(1, 1'b0, 1'b0, 1'b0, 3'b100);
		poll(1, 1'b0, 1'b0, 1'b0, 3'b100);
		read_action();
		set_all_thresholds('1, '1, '1);
		poll(1, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(65535, 1'b0, 1'b0, 1'b0, 3'b000);
		poll(1, 1'b0, 1'b0, 1'b1, 3'b000);
		poll(65536, 1'b0, 1'b0, 1'b0, 3'b000);
	endtask

	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input logic [THR_W-1:0] lp, input logic [THR_W-1:0] sp,
			input logic [THR_W-1:0] db, input int count);
		set_all_thresholds(lp, sp, db);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		random_words(count);
	endtask

	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req++;
		random_words(100);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_poll_and_encoder();
		test_switch_timing();
		test_button_debounce();
		test_event_priority();
		test_threshold_extremes();
		test_random_phase(14, 46, 16'd1000, 16'd20, 16'd20, 200);
		test_random_phase(46, 14, 16'd300, 16'd5, 16'd0, 200);
		test_random_phase(0, 0, 16'd4, 16'd12, 16'd3, 130);
		test_result_backpressure();
		settle();
		repeat (8) @(posedge clk);
		$display("run covered %0d words (%0d checked): encoder turns, switch holds,",
			words_sent, words_checked);
		$display("button debounce and reads under %0d threshold sets and a long result stall",
			settings_used);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ebiq_pkg.sv
rtl/ebiq_btn_debounce.sv
rtl/encoder_button_input_qualifier.sv
tb/tb_top.sv
